>>> rtl/core/isq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isq_pkg: shared types and constants of the interrupt source queue
// Field widths, action codes and the result word format.
// ----------------------------------------------------------------------------
package isq_pkg;

    localparam int DEV_W           = 4;
    localparam int MASK_W          = 16;
    localparam int NUM_DEVICES_DEF = 16;

    typedef enum logic {
        ACT_REQUEST = 1'b0,
        ACT_READ    = 1'b1
    } t_action;

    typedef struct packed {
        logic             accepted;
        logic             found;
        logic [DEV_W-1:0] source_device;
        logic             more_pending;
    } t_result;

endpackage

>>> rtl/core/isq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isq_in_if / isq_out_if: valid/ready channels of the interrupt source queue
// Request/read words in, result words out.
// ----------------------------------------------------------------------------
interface isq_in_if import isq_pkg::*; ();
    logic             valid;
    logic             ready;
    t_action          action;
    logic [DEV_W-1:0] device;

    modport source (output valid, action, device, input ready);
    modport sink   (input valid, action, device, output ready);
endinterface

interface isq_out_if import isq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             accepted;
    logic             found;
    logic [DEV_W-1:0] source_device;
    logic             more_pending;

    modport source (output valid, accepted, found, source_device, more_pending, input ready);
    modport sink   (input valid, accepted, found, source_device, more_pending, output ready);
endinterface

>>> rtl/core/isq_src_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isq_src_ram: device number storage of the queue
// One write port, one registered read port, write data forwarded on a
// same-address collision.
// ----------------------------------------------------------------------------
module isq_src_ram import isq_pkg::*; #(
    parameter int DEPTH  = NUM_DEVICES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DEV_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DEV_W-1:0]  o_rdata
);

    logic [DEV_W-1:0] r_mem [DEPTH];
    logic [DEV_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/isq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isq_ctrl: pending flags, queue pointers and enable register
// Decides push or pop for one word and forms its result.
// ----------------------------------------------------------------------------
module isq_ctrl import isq_pkg::*; #(
    parameter int NUM_DEVICES = NUM_DEVICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_data,
    input  logic              i_fire,
    input  t_action           i_action,
    input  logic [DEV_W-1:0]  i_device,
    output t_result           o_result
);

    localparam int PTR_W = $clog2(NUM_DEVICES);
    localparam int CNT_W = $clog2(NUM_DEVICES + 1);

    logic [NUM_DEVICES-1:0] r_pending, n_pending;
    logic [PTR_W-1:0]       r_head, n_head;
    logic [PTR_W-1:0]       r_tail, n_tail;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [MASK_W-1:0]      r_enable;

    logic [PTR_W-1:0] dev_idx;
    logic [PTR_W-1:0] pop_idx;
    logic [DEV_W-1:0] head_data;
    logic             dev_ok;
    logic             push_ok;
    logic             pop_ok;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(NUM_DEVICES - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    assign dev_idx = PTR_W'(i_device);
    assign pop_idx = PTR_W'(head_data);
    assign dev_ok  = 32'(i_device) < 32'(NUM_DEVICES);

    assign push_ok = i_fire && (i_action == ACT_REQUEST) && dev_ok
                     && r_enable[i_device] && !r_pending[dev_idx]
                     && (r_count < CNT_W'(NUM_DEVICES));
    assign pop_ok  = i_fire && (i_action == ACT_READ) && (r_count != '0);

    always_comb begin
        n_pending = r_pending;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        if (push_ok) begin
            n_pending[dev_idx] = 1'b1;
            n_tail             = ptr_inc(r_tail);
            n_count            = r_count + CNT_W'(1);
        end
        if (pop_ok) begin
            n_pending[pop_idx] = 1'b0;
            n_head             = ptr_inc(r_head);
            n_count            = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_enable  <= '0;
        end else begin
            r_pending <= n_pending;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            if (i_cfg_we) begin
                r_enable <= i_cfg_data;
            end
        end
    end

    // read port tracks the head so the oldest entry is ready every cycle
    isq_src_ram #(
        .DEPTH  (NUM_DEVICES),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push_ok),
        .i_waddr (r_tail),
        .i_wdata (i_device),
        .i_raddr (n_head),
        .o_rdata (head_data)
    );

    always_comb begin
        o_result               = '0;
        o_result.accepted      = push_ok;
        o_result.found         = pop_ok;
        o_result.source_device = pop_ok ? head_data : '0;
        o_result.more_pending  = pop_ok && (r_count != CNT_W'(1));
    end

endmodule

>>> rtl/core/interrupt_source_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_source_queue: deduplicating FIFO of interrupting devices
// Queues each enabled device at most once and hands them out oldest first.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one word per request (action 0, device) or read (action 1).
//   o_out returns one result word for every input word, in order.
//   i_cfg_we/i_cfg_data write the 16-bit enable mask; write only when idle.
// Timing:
//   A word accepted into the input register is decided there and stored in the
//   output register once that register is free, and is shown from then on;
//   one word per cycle sustained while o_out is not stalled. The pending flags,
//   pointers and the registered head-of-queue memory read are all updated
//   together with the output register when the word is decided.
// Reset:
//   Clears the pending flags, pointers, count, enable mask and both valid
//   bits; queue memory contents are left as they are.
// Backpressure:
//   While o_out is stalled the result holds; the input register still takes
//   one more word, then i_in.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module interrupt_source_queue import isq_pkg::*; #(
    parameter int NUM_DEVICES = NUM_DEVICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_data,
    isq_in_if.sink            i_in,
    isq_out_if.source         o_out
);

    logic             r_in_valid;
    t_action          r_action;
    logic [DEV_W-1:0] r_device;
    logic             r_out_valid;
    t_result          r_result;
    t_result          n_result;
    logic             proc_fire;

    assign proc_fire  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (proc_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_action <= i_in.action;
            r_device <= i_in.device;
        end
        if (proc_fire) begin
            r_result <= n_result;
        end
    end

    isq_ctrl #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (proc_fire),
        .i_action   (r_action),
        .i_device   (r_device),
        .o_result   (n_result)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.accepted      = r_result.accepted;
    assign o_out.found         = r_result.found;
    assign o_out.source_device = r_result.source_device;
    assign o_out.more_pending  = r_result.more_pending;

endmodule

>>> rtl/core/isq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isq_checker: port-level checks of the interrupt source queue
// Result word consistency, reset behavior and output hold under stall.
// ----------------------------------------------------------------------------
module isq_checker import isq_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_accepted,
    input logic             i_found,
    input logic [DEV_W-1:0] i_source_device,
    input logic             i_more_pending
);

    // a word is either a request result or a read result
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_accepted && i_found))
        else $error("accepted and found both set");

    // empty read / request result carries no device and no more flag
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> (i_source_device == '0) && !i_more_pending)
        else $error("payload set without a pop");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_accepted)
            && $stable(i_found) && $stable(i_source_device) && $stable(i_more_pending))
        else $error("stalled result changed");

endmodule

bind interrupt_source_queue isq_checker u_isq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_accepted      (o_out.accepted),
    .i_found         (o_out.found),
    .i_source_device (o_out.source_device),
    .i_more_pending  (o_out.more_pending)
);
